### design/csvft_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and helpers for the CSV field tokenizer.
package csvft_pkg;

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_PLAIN  = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_QSEEN  = 3'd3,
    MODE_ESC    = 3'd4,
    MODE_SKIP   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    CMD_SPACE   = 2'd0,
    CMD_CONTENT = 2'd1,
    CMD_END     = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        line_end;
    logic        dropped;
    logic        last;
  } cmd_t;

  localparam logic [1:0] QUOTE_NONE     = 2'd0;
  localparam logic [1:0] QUOTE_DOUBLE   = 2'd1;
  localparam logic [1:0] QUOTE_SINGLE   = 2'd2;
  localparam logic [1:0] QUOTE_BACKTICK = 2'd3;

  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_DQUOTE   = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE   = 8'h27;
  localparam logic [7:0] CHAR_COMMA    = 8'h2C;
  localparam logic [7:0] CHAR_BSLASH   = 8'h5C;
  localparam logic [7:0] CHAR_BACKTICK = 8'h60;
  localparam logic [7:0] CHAR_N        = 8'h6E;

  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;

  function automatic logic [7:0] quote_char(input logic [1:0] code);
    logic [7:0] ch;
    unique case (code)
      QUOTE_NONE:     ch = 8'h00;
      QUOTE_DOUBLE:   ch = CHAR_DQUOTE;
      QUOTE_SINGLE:   ch = CHAR_SQUOTE;
      QUOTE_BACKTICK: ch = CHAR_BACKTICK;
    endcase
    return ch;
  endfunction

endpackage

### design/csv_field_tokenizer.sv
`timescale 1ns / 1ps
// CSV field tokenizer top level: parser front end, command queue and output back end.
//
// Input channel: one text byte per transaction on in_byte (in_valid / in_stall).
// A newline ends the line. Output channel: one result per transaction, either a
// field content byte (byte_valid) or a field-end marker (field_end, with line_end
// on the last field of a line and space_dropped when inner whitespace was lost).
// last_of_run marks the final result caused by one input byte.
// Throughput: the front end takes one byte per cycle while the queue has room;
// after a backslash inside quotes that is not followed by 'n', the following
// byte is handled a second time while in_stall is high. The back end sends one
// result per cycle while out_stall is low. A content byte that releases k held
// whitespace bytes first waits for a read of the whitespace memory and then
// produces k + 1 results back to back; this back end rate sets the sustained
// throughput while whitespace is released. A content byte with nothing held
// reaches the output through the command queue, then the output register.
// A four-entry command queue separates the two halves, so when the receiver
// stalls the front end keeps accepting until the queue fills, then raises
// in_stall. Results are held stable while out_stall is high. Reset clears
// the parser state, the queue and out_valid; the whitespace memory needs no pass.
module csv_field_tokenizer #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       field_end,
  output logic       line_end,
  output logic       space_dropped,
  output logic       last_of_run
);

  localparam int CntW = $clog2(PENDING_DEPTH + 2);
  localparam int QW   = $bits(csvft_pkg::cmd_t) + CntW;
  localparam logic [CntW-1:0] DepthC = CntW'(PENDING_DEPTH);

  logic            f_valid, f_ready;
  csvft_pkg::cmd_t f_cmd;
  logic [CntW-1:0] f_cnt;
  logic            q_valid, q_pop;
  logic [QW-1:0]   q_data;
  csvft_pkg::cmd_t q_cmd;
  logic [CntW-1:0] q_cnt;

  csvft_front #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_cnt   (f_cnt),
    .cmd_ready (f_ready)
  );

  csvft_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_data  ({f_cmd, f_cnt}),
    .wr_ready (f_ready),
    .rd_valid (q_valid),
    .rd_data  (q_data),
    .rd_pop   (q_pop)
  );

  assign q_cmd = csvft_pkg::cmd_t'(q_data[QW-1:CntW]);
  assign q_cnt = q_data[CntW-1:0];

  csvft_back #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (q_valid),
    .cmd           (q_cmd),
    .cmd_cnt       (q_cnt),
    .cmd_pop       (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .field_end     (field_end),
    .line_end      (line_end),
    .space_dropped (space_dropped),
    .last_of_run   (last_of_run)
  );

  a_line_end_on_field_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_end |-> field_end)
    else $error("line_end result without field_end");

  a_dropped_on_field_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && space_dropped |-> field_end && !byte_valid)
    else $error("space_dropped on a content result");

  a_space_index_in_range: assert property (@(posedge clk) disable iff (rst)
    q_valid && (q_cmd.kind == csvft_pkg::CMD_SPACE) |-> q_cnt < DepthC)
    else $error("whitespace write beyond pending depth");

  a_flush_count_in_range: assert property (@(posedge clk) disable iff (rst)
    q_valid && (q_cmd.kind == csvft_pkg::CMD_CONTENT) |-> q_cnt <= DepthC)
    else $error("flush count beyond pending depth");

endmodule

### design/csvft_front.sv
`timescale 1ns / 1ps
// Front end: parses input bytes and issues space, content and field-end commands.
module csvft_front #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_byte,
  output logic                                 cmd_valid,
  output csvft_pkg::cmd_t                      cmd,
  output logic [$clog2(PENDING_DEPTH + 2)-1:0] cmd_cnt,
  input  logic                                 cmd_ready
);

  localparam int CntW = $clog2(PENDING_DEPTH + 2);
  localparam logic [CntW-1:0] DepthC = CntW'(PENDING_DEPTH);
  localparam logic [CntW-1:0] OverC  = CntW'(PENDING_DEPTH + 1);

  csvft_pkg::mode_t mode, mode_next;
  logic [1:0]       open_quote, open_quote_next;
  logic             content_seen, content_seen_next;
  logic [CntW-1:0]  pending_count, pending_count_next;
  logic             overflow_seen, overflow_seen_next;
  logic             replay, replay_next;
  logic [7:0]       replay_byte;

  logic [7:0] cur_byte;
  logic [7:0] qc;
  logic       step;
  logic       is_sep;
  logic       push;
  logic       do_content;
  logic       do_end;
  logic       content_last;
  logic [7:0] content_byte;

  // A replayed byte is the one that followed a backslash other than 'n'.
  assign cur_byte  = replay ? replay_byte : in_byte;
  assign step      = (replay || in_valid) && cmd_ready;
  assign in_stall  = replay || !cmd_ready;
  assign cmd_valid = step && push;
  assign qc        = csvft_pkg::quote_char(open_quote);
  assign is_sep    = (cur_byte == csvft_pkg::CHAR_COMMA) ||
                     (cur_byte == csvft_pkg::CHAR_NEWLINE);

  always_comb begin
    mode_next          = mode;
    open_quote_next    = open_quote;
    content_seen_next  = content_seen;
    pending_count_next = pending_count;
    overflow_seen_next = overflow_seen;
    replay_next        = 1'b0;
    do_content         = 1'b0;
    do_end             = 1'b0;
    content_byte       = cur_byte;
    content_last       = 1'b1;
    push               = 1'b0;
    cmd.kind           = csvft_pkg::CMD_SPACE;
    cmd.data           = 8'h00;
    cmd.line_end       = 1'b0;
    cmd.dropped        = 1'b0;
    cmd.last           = 1'b0;
    cmd_cnt            = '0;

    unique case (mode)
      csvft_pkg::MODE_PLAIN: begin
        if (is_sep) do_end = 1'b1;
        else do_content = 1'b1;
      end
      csvft_pkg::MODE_QUOTED: begin
        if (cur_byte == csvft_pkg::CHAR_NEWLINE) do_end = 1'b1;
        else if (cur_byte == qc) mode_next = csvft_pkg::MODE_QSEEN;
        else if (cur_byte == csvft_pkg::CHAR_BSLASH) mode_next = csvft_pkg::MODE_ESC;
        else do_content = 1'b1;
      end
      csvft_pkg::MODE_QSEEN: begin
        if (cur_byte == qc) begin
          do_content   = 1'b1;
          content_byte = qc;
          mode_next    = csvft_pkg::MODE_QUOTED;
        end else begin
          mode_next = csvft_pkg::MODE_SKIP;
          do_end    = is_sep;
        end
      end
      csvft_pkg::MODE_ESC: begin
        mode_next  = csvft_pkg::MODE_QUOTED;
        do_content = 1'b1;
        if (cur_byte == csvft_pkg::CHAR_N) begin
          content_byte = csvft_pkg::CHAR_NEWLINE;
        end else begin
          // The backslash is literal; the byte itself is replayed from replay_byte.
          content_byte = csvft_pkg::CHAR_BSLASH;
          replay_next  = 1'b1;
          content_last = !((cur_byte == csvft_pkg::CHAR_NEWLINE) ||
                           ((cur_byte != qc) && (cur_byte != csvft_pkg::CHAR_BSLASH) &&
                            (cur_byte > csvft_pkg::CHAR_SPACE)));
        end
      end
      csvft_pkg::MODE_SKIP: begin
        do_end = is_sep;
      end
      default: begin
        if (is_sep) begin
          do_end = 1'b1;
        end else if (cur_byte == csvft_pkg::CHAR_DQUOTE) begin
          open_quote_next = csvft_pkg::QUOTE_DOUBLE;
          mode_next       = csvft_pkg::MODE_QUOTED;
        end else if (cur_byte == csvft_pkg::CHAR_SQUOTE) begin
          open_quote_next = csvft_pkg::QUOTE_SINGLE;
          mode_next       = csvft_pkg::MODE_QUOTED;
        end else if (cur_byte == csvft_pkg::CHAR_BACKTICK) begin
          open_quote_next = csvft_pkg::QUOTE_BACKTICK;
          mode_next       = csvft_pkg::MODE_QUOTED;
        end else begin
          mode_next  = csvft_pkg::MODE_PLAIN;
          do_content = 1'b1;
        end
      end
    endcase

    if (do_content) begin
      if (content_byte <= csvft_pkg::CHAR_SPACE) begin
        // Leading whitespace is dropped; inner whitespace waits in the back end.
        if (content_seen) begin
          if (pending_count < DepthC) begin
            push               = 1'b1;
            cmd.kind           = csvft_pkg::CMD_SPACE;
            cmd.data           = content_byte;
            cmd_cnt            = pending_count;
            pending_count_next = pending_count + CntW'(1);
          end else begin
            pending_count_next = OverC;
          end
        end
      end else begin
        push     = 1'b1;
        cmd.kind = csvft_pkg::CMD_CONTENT;
        cmd.data = content_byte;
        cmd.last = content_last;
        if (pending_count > DepthC) begin
          cmd_cnt            = DepthC;
          overflow_seen_next = 1'b1;
        end else begin
          cmd_cnt = pending_count;
        end
        pending_count_next = '0;
        content_seen_next  = 1'b1;
      end
    end

    if (do_end) begin
      push               = 1'b1;
      cmd.kind           = csvft_pkg::CMD_END;
      cmd.line_end       = (cur_byte == csvft_pkg::CHAR_NEWLINE);
      cmd.dropped        = overflow_seen;
      cmd.last           = 1'b1;
      mode_next          = csvft_pkg::MODE_START;
      open_quote_next    = csvft_pkg::QUOTE_NONE;
      content_seen_next  = 1'b0;
      pending_count_next = '0;
      overflow_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= csvft_pkg::MODE_START;
      open_quote    <= csvft_pkg::QUOTE_NONE;
      content_seen  <= 1'b0;
      pending_count <= '0;
      overflow_seen <= 1'b0;
      replay        <= 1'b0;
    end else if (step) begin
      mode          <= mode_next;
      open_quote    <= open_quote_next;
      content_seen  <= content_seen_next;
      pending_count <= pending_count_next;
      overflow_seen <= overflow_seen_next;
      replay        <= replay_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      replay_byte <= cur_byte;
    end
  end

endmodule

### design/csvft_queue.sv
`timescale 1ns / 1ps
// Small command queue between the front end and the back end.
module csvft_queue #(
  parameter int WIDTH = 19
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  input  logic [WIDTH-1:0] wr_data,
  output logic             wr_ready,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data,
  input  logic             rd_pop
);

  localparam int PtrW = csvft_pkg::QUEUE_PTR_W;
  localparam logic [PtrW:0] FullC = (PtrW + 1)'(csvft_pkg::QUEUE_DEPTH);

  logic [WIDTH-1:0] slots [csvft_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [PtrW:0]    fill;
  logic             push, pop;

  assign wr_ready = (fill != FullC);
  assign rd_valid = (fill != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PtrW'(1);
      if (pop) rd_ptr <= rd_ptr + PtrW'(1);
      if (push && !pop) fill <= fill + (PtrW + 1)'(1);
      else if (pop && !push) fill <= fill - (PtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

### design/csvft_back.sv
`timescale 1ns / 1ps
// Back end: holds pending whitespace, flushes it before content and drives the result register.
module csvft_back #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  input  csvft_pkg::cmd_t                      cmd,
  input  logic [$clog2(PENDING_DEPTH + 2)-1:0] cmd_cnt,
  output logic                                 cmd_pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           out_byte,
  output logic                                 byte_valid,
  output logic                                 field_end,
  output logic                                 line_end,
  output logic                                 space_dropped,
  output logic                                 last_of_run
);

  localparam int CntW = $clog2(PENDING_DEPTH + 2);
  localparam int IdxW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  logic [7:0]      pending_space [PENDING_DEPTH];
  logic [7:0]      rd_data;
  logic            rd_en;
  logic [CntW-1:0] rd_addr;
  logic [CntW-1:0] fl_cnt, fl_cnt_next, fl_cnt_inc;
  logic            rd_ok, rd_ok_next;
  logic            advance;
  logic            load;
  logic [7:0]      load_byte;
  logic            load_bv, load_fe, load_le, load_sd, load_last;

  assign advance    = !out_valid || !out_stall;
  assign fl_cnt_inc = fl_cnt + CntW'(1);

  // fl_cnt counts pending bytes already sent for the content command at the head;
  // rd_ok means rd_data holds entry fl_cnt.
  always_comb begin
    cmd_pop     = 1'b0;
    load        = 1'b0;
    load_byte   = 8'h00;
    load_bv     = 1'b0;
    load_fe     = 1'b0;
    load_le     = 1'b0;
    load_sd     = 1'b0;
    load_last   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = fl_cnt;
    fl_cnt_next = fl_cnt;
    rd_ok_next  = rd_ok;
    if (cmd_valid) begin
      unique case (cmd.kind)
        csvft_pkg::CMD_SPACE: begin
          cmd_pop = 1'b1;
        end
        csvft_pkg::CMD_END: begin
          if (advance) begin
            load      = 1'b1;
            load_fe   = 1'b1;
            load_le   = cmd.line_end;
            load_sd   = cmd.dropped;
            load_last = cmd.last;
            cmd_pop   = 1'b1;
          end
        end
        csvft_pkg::CMD_CONTENT: begin
          if (fl_cnt == cmd_cnt) begin
            if (advance) begin
              load        = 1'b1;
              load_byte   = cmd.data;
              load_bv     = 1'b1;
              load_last   = cmd.last;
              cmd_pop     = 1'b1;
              fl_cnt_next = '0;
              rd_ok_next  = 1'b0;
            end
          end else if (!rd_ok) begin
            rd_en      = 1'b1;
            rd_addr    = fl_cnt;
            rd_ok_next = 1'b1;
          end else if (advance) begin
            load        = 1'b1;
            load_byte   = rd_data;
            load_bv     = 1'b1;
            fl_cnt_next = fl_cnt_inc;
            if (fl_cnt_inc != cmd_cnt) begin
              rd_en   = 1'b1;
              rd_addr = fl_cnt_inc;
            end else begin
              rd_ok_next = 1'b0;
            end
          end
        end
        default: begin
          cmd_pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && (cmd.kind == csvft_pkg::CMD_SPACE)) begin
      pending_space[cmd_cnt[IdxW-1:0]] <= cmd.data;
    end
    if (rd_en) begin
      rd_data <= pending_space[rd_addr[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fl_cnt    <= '0;
      rd_ok     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      fl_cnt <= fl_cnt_next;
      rd_ok  <= rd_ok_next;
      if (advance) out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= load_byte;
      byte_valid    <= load_bv;
      field_end     <= load_fe;
      line_end      <= load_le;
      space_dropped <= load_sd;
      last_of_run   <= load_last;
    end
  end

endmodule
